@@ sv/inversion_table_to_permutation_unit_macros.svh @@
// Assertion macros for the inversion table decoder
`ifndef INVERSION_TABLE_TO_PERMUTATION_UNIT_MACROS_SVH
`define INVERSION_TABLE_TO_PERMUTATION_UNIT_MACROS_SVH

// same-cycle implication, sampled on clk, off while arst_n is low
`define ITP_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("itp: same-cycle check failed");

// next-cycle implication
`define ITP_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("itp: next-cycle check failed");

`endif

@@ sv/itp_pkg.sv @@
// Shared constants and controller/datapath interface types
`default_nettype none

package itp_pkg;

	localparam int MAX_ITEMS_DEFAULT = 16;
	localparam int COUNT_W           = 5;
	localparam int ENTRY_W           = 4;
	localparam int INDEX_OUT_W       = 4;

	localparam logic [COUNT_W-1:0] COUNT_RESET = 5'd16;

	typedef struct packed {
		logic load;      // store an entry at the load position
		logic dec_init;  // point the decoder at the highest item
		logic rd;        // read entry of the current item
		logic ins;       // insert current item into the slot row
		logic out_init;  // load the slot countdown
		logic shift;     // drop the head slot after an output transaction
	} itp_cmd_t;

	typedef struct packed {
		logic load_last;  // load position is N-1
		logic ins_last;   // current item is item 0
		logic out_last;   // one slot left to send
	} itp_status_t;

endpackage

`default_nettype wire

@@ sv/itp_ctrl.sv @@
// Sequencer: load, decode (read/insert per item) and drain phases
`default_nettype none

module itp_ctrl
	import itp_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	input  wire logic        out_ready,
	input  wire itp_status_t status,
	output itp_cmd_t         cmd,
	output logic             in_ready,
	output logic             out_valid
);

	localparam logic [1:0] ST_LOAD = 2'd0;
	localparam logic [1:0] ST_RD   = 2'd1;
	localparam logic [1:0] ST_INS  = 2'd2;
	localparam logic [1:0] ST_OUT  = 2'd3;

	logic [1:0] state_q;
	logic [1:0] state_d;

	assign in_ready  = (state_q == ST_LOAD);
	assign out_valid = (state_q == ST_OUT);

	always_comb begin
		cmd          = '0;
		cmd.load     = in_valid && in_ready;
		cmd.dec_init = cmd.load && status.load_last;
		cmd.rd       = (state_q == ST_RD);
		cmd.ins      = (state_q == ST_INS);
		cmd.out_init = cmd.ins && status.ins_last;
		cmd.shift    = out_valid && out_ready;
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_LOAD: begin
				if (cmd.dec_init) state_d = ST_RD;
			end
			ST_RD: state_d = ST_INS;
			ST_INS: begin
				state_d = status.ins_last ? ST_OUT : ST_RD;
			end
			ST_OUT: begin
				if (cmd.shift && status.out_last) state_d = ST_LOAD;
			end
			default: state_d = ST_LOAD;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_LOAD;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

`default_nettype wire

@@ sv/itp_datapath.sv @@
// Count register, entry memory, insertion slot row and counters
`default_nettype none

module itp_datapath
	import itp_pkg::*;
#(
	parameter int MAX_ITEMS = MAX_ITEMS_DEFAULT
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         cfg_we,
	input  wire logic [COUNT_W-1:0]           cfg_count,
	input  wire logic [ENTRY_W-1:0]           entry_in,
	input  wire itp_cmd_t                     cmd,
	output itp_status_t                       status,
	output logic [$clog2(MAX_ITEMS)-1:0]      head_index
);

	localparam int IW = $clog2(MAX_ITEMS);
	localparam int CW = $clog2(MAX_ITEMS + 1);
	localparam int EW = (CW > ENTRY_W) ? CW : ENTRY_W;
	localparam int MW = (COUNT_W > CW) ? COUNT_W : CW;

	logic [COUNT_W-1:0] count_q;
	logic [IW-1:0]      k_q;
	logic [IW-1:0]      i_q;
	logic [CW-1:0]      rem_q;
	logic [ENTRY_W-1:0] entry_rd_q;

	logic [ENTRY_W-1:0] entry_mem [MAX_ITEMS];
	logic [IW-1:0]      order_q   [MAX_ITEMS];
	logic [IW-1:0]      order_ins [MAX_ITEMS];

	logic [MW-1:0] cnt_ext;
	logic [MW-1:0] n_wide;
	logic [CW-1:0] n;
	logic [IW-1:0] kk;
	logic [CW-1:0] lim;
	logic [EW-1:0] e;

	// effective item count: 0 acts as 1, above capacity acts as capacity
	always_comb begin
		cnt_ext = MW'(count_q);
		priority if (cnt_ext == '0) begin
			n_wide = MW'(1);
		end else if (cnt_ext > MW'(MAX_ITEMS)) begin
			n_wide = MW'(MAX_ITEMS);
		end else begin
			n_wide = cnt_ext;
		end
		n = n_wide[CW-1:0];
	end

	assign kk  = (CW'(k_q) >= n) ? '0 : k_q;
	assign lim = n - CW'(1) - CW'(i_q);
	// entry clamped to the number of larger items already placed
	assign e   = (EW'(entry_rd_q) > EW'(lim)) ? EW'(lim) : EW'(entry_rd_q);

	assign status.load_last = (CW'(kk) == (n - CW'(1)));
	assign status.ins_last  = (i_q == '0);
	assign status.out_last  = (rem_q == CW'(1));

	assign head_index = order_q[0];

	// list insertion: cells from position e onward move one place along
	always_comb begin
		order_ins[0] = (e == '0) ? i_q : order_q[0];
		for (int j = 1; j < MAX_ITEMS; j++) begin
			if (EW'(j) == e) begin
				order_ins[j] = i_q;
			end else if (EW'(j) > e) begin
				order_ins[j] = order_q[j-1];
			end else begin
				order_ins[j] = order_q[j];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= COUNT_RESET;
			k_q     <= '0;
			i_q     <= '0;
			rem_q   <= '0;
		end else begin
			if (cfg_we) begin
				count_q <= cfg_count;
				k_q     <= '0;
			end else if (cmd.load) begin
				k_q <= status.load_last ? '0 : kk + IW'(1);
			end
			if (cmd.dec_init) begin
				i_q <= IW'(n - CW'(1));
			end else if (cmd.ins) begin
				i_q <= i_q - IW'(1);
			end
			if (cmd.out_init) begin
				rem_q <= n;
			end else if (cmd.shift) begin
				rem_q <= rem_q - CW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			entry_mem[kk] <= entry_in;
		end
		if (cmd.rd) begin
			entry_rd_q <= entry_mem[i_q];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.ins) begin
			for (int j = 0; j < MAX_ITEMS; j++) begin
				order_q[j] <= order_ins[j];
			end
		end else if (cmd.shift) begin
			for (int j = 0; j < MAX_ITEMS - 1; j++) begin
				order_q[j] <= order_q[j+1];
			end
		end
	end

endmodule

`default_nettype wire

@@ sv/inversion_table_to_permutation_unit.sv @@
// Top level of the inversion table to permutation decoder
//
//   channel  | direction | signals
//   ---------+-----------+---------------------------------------------
//   cfg      | in        | cfg_valid, cfg_ready, module_count
//   in       | in        | in_valid, in_ready, larger_before
//   out      | out       | out_valid, out_ready, module_index, last_slot
//
// Entries load one per in transaction; entries before the last give no results.
// After the N-th entry the decoder handles the items one at a time (entry memory
// read, then one insertion into the slot row), and then drains N slots, one
// per out transaction. Input is not taken during decode or drain.
// Reset clears the count (to 16), the load position and the sequencer.
// A stalled out channel holds the head slot; a cfg write resets the load position.
`default_nettype none

module inversion_table_to_permutation_unit
	import itp_pkg::*;
#(
	parameter int MAX_ITEMS = MAX_ITEMS_DEFAULT
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   cfg_valid,
	output logic                        cfg_ready,
	input  wire logic [COUNT_W-1:0]     module_count,
	input  wire logic                   in_valid,
	output logic                        in_ready,
	input  wire logic [ENTRY_W-1:0]     larger_before,
	output logic                        out_valid,
	input  wire logic                   out_ready,
	output logic [INDEX_OUT_W-1:0]      module_index,
	output logic                        last_slot
);

	`include "inversion_table_to_permutation_unit_macros.svh"

	localparam int IW = $clog2(MAX_ITEMS);

	itp_cmd_t      cmd;
	itp_status_t   status;
	logic [IW-1:0] head_index;
	logic [IW+INDEX_OUT_W-1:0] head_ext;

	assign cfg_ready = 1'b1;

	itp_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.out_ready (out_ready),
		.status    (status),
		.cmd       (cmd),
		.in_ready  (in_ready),
		.out_valid (out_valid)
	);

	itp_datapath #(
		.MAX_ITEMS (MAX_ITEMS)
	) u_datapath (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_valid && cfg_ready),
		.cfg_count  (module_count),
		.entry_in   (larger_before),
		.cmd        (cmd),
		.status     (status),
		.head_index (head_index)
	);

	assign head_ext     = {{INDEX_OUT_W{1'b0}}, head_index};
	assign module_index = head_ext[INDEX_OUT_W-1:0];
	assign last_slot    = status.out_last;

	`ITP_ASSERT_NOW(a_no_load_while_draining, out_valid, !in_ready)
	`ITP_ASSERT_NEXT(a_final_slot_ends_drain, out_valid && out_ready && last_slot, in_ready && !out_valid)
	`ITP_ASSERT_NEXT(a_drain_continues, out_valid && out_ready && !last_slot, out_valid)

endmodule

`default_nettype wire
